>>> rtl/dra_pkg.sv
// Package for the dirty rectangle accumulator: box type, result kinds,
// status codes and controller command/status bundles. No dependencies.
package dra_pkg;

  localparam int MaxRects = 16;
  localparam int IdxW     = $clog2(MaxRects);
  localparam int CntW     = IdxW + 1;

  typedef struct packed {
    logic [15:0] y2;
    logic [15:0] x2;
    logic [15:0] y1;
    logic [15:0] x1;
  } box_t;

  localparam logic [1:0] MODE_MARK = 2'd0;
  localparam logic [1:0] MODE_REQ  = 2'd1;
  localparam logic [1:0] MODE_GRAB = 2'd2;

  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_REPLY  = 2'd1;
  localparam logic [1:0] KIND_RECT   = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SCAN  = 2'd1;
  localparam logic [1:0] ST_ZERO_MAX = 2'd2;

  // datapath operations
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1; // capture input beat
  localparam logic [2:0] OP_MRD    = 3'd2; // read store[a], store[b]
  localparam logic [2:0] OP_MTEST  = 3'd3; // area test, merge if it passes
  localparam logic [2:0] OP_MMOVE  = 3'd4; // store[b] <= store[last] (read done)
  localparam logic [2:0] OP_CRD    = 3'd5; // read store[i] for collapse
  localparam logic [2:0] OP_CACC   = 3'd6; // acc <= union(acc, rd)
  localparam logic [2:0] OP_APPEND = 3'd7; // store[total] <= input rect

  typedef struct packed {
    logic [2:0]      op;
    logic [IdxW-1:0] a;
    logic [IdxW-1:0] b;
    logic            wr_acc0;  // store[0] <= acc
  } dp_cmd_t;

  typedef struct packed {
    logic merge_ok;
  } dp_sts_t;

  function automatic box_t box_union(box_t p, box_t q);
    box_t r;
    r.x1 = (p.x1 < q.x1) ? p.x1 : q.x1;
    r.y1 = (p.y1 < q.y1) ? p.y1 : q.y1;
    r.x2 = (p.x2 > q.x2) ? p.x2 : q.x2;
    r.y2 = (p.y2 > q.y2) ? p.y2 : q.y2;
    return r;
  endfunction

endpackage

>>> rtl/dra_datapath.sv
// Datapath of the dirty rectangle accumulator: rectangle store, union and
// area test, collapse accumulator. Depends on dra_pkg.
module dra_datapath (
  input  logic            clk,
  input  dra_pkg::box_t   in_rect,
  input  dra_pkg::dp_cmd_t cmd,
  input  logic [dra_pkg::IdxW-1:0] wr_idx,
  output dra_pkg::dp_sts_t sts,
  output dra_pkg::box_t   rd_q
);
  import dra_pkg::*;

  box_t store [MaxRects];
  box_t ra, rb, rnew, acc, ubox;
  logic signed [17:0] uw, uh, aw, ah, bw, bh;
  logic signed [34:0] ua_r, aa_r, ba_r;
  logic               mrd_d;
  logic               mul_v;

  assign ubox = box_union(ra, rb);
  assign uw = $signed({2'b0, ubox.x2}) - $signed({2'b0, ubox.x1});
  assign uh = $signed({2'b0, ubox.y2}) - $signed({2'b0, ubox.y1});
  assign aw = $signed({2'b0, ra.x2}) - $signed({2'b0, ra.x1});
  assign ah = $signed({2'b0, ra.y2}) - $signed({2'b0, ra.y1});
  assign bw = $signed({2'b0, rb.x2}) - $signed({2'b0, rb.x1});
  assign bh = $signed({2'b0, rb.y2}) - $signed({2'b0, rb.y1});

  // three 18x18 products registered, then add and compare
  always_ff @(posedge clk) begin
    ua_r <= 35'(uw) * 35'(uh);
    aa_r <= 35'(aw) * 35'(ah);
    ba_r <= 35'(bw) * 35'(bh);
    mrd_d <= (cmd.op == OP_MRD);
    mul_v <= mrd_d;
  end

  assign sts.merge_ok = ($signed({ua_r[34], ua_r}) <=
                         ($signed({aa_r[34], aa_r}) + $signed({ba_r[34], ba_r})));
  assign rd_q = ra;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: rnew <= in_rect;
      OP_MRD: begin
        ra <= store[cmd.a];
        rb <= store[cmd.b];
      end
      OP_MTEST: begin
        if (sts.merge_ok) begin
          store[cmd.a] <= ubox;
          ra <= ubox;
        end
      end
      OP_MMOVE: store[cmd.b] <= store[wr_idx];
      OP_CRD: begin
        ra <= store[cmd.a];
        if (cmd.a == '0) acc <= store[cmd.a];
      end
      OP_CACC: acc <= box_union(acc, ra);
      OP_APPEND: store[wr_idx] <= rnew;
      default: ;
    endcase
    if (cmd.wr_acc0) store[0] <= acc;
  end

  // product registers track the read that fed them
  assert property (@(posedge clk) cmd.op == OP_MTEST |-> mul_v)
    else $error("area test without fresh products");
endmodule

>>> rtl/dra_ctrl.sv
// Controller of the dirty rectangle accumulator: sequences merge, collapse,
// append and grab readout; owns the count and the pending flag. Uses dra_pkg.
module dra_ctrl (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_valid,
  output logic        s_ready,
  input  logic [1:0]  mode,
  input  logic        scan,
  input  logic [4:0]  lim,
  output dra_pkg::dp_cmd_t cmd,
  output logic [dra_pkg::IdxW-1:0] wr_idx,
  input  dra_pkg::dp_sts_t sts,
  input  dra_pkg::box_t rd_q,
  output logic        o_valid,
  input  logic        o_ready,
  output logic [1:0]  o_kind,
  output dra_pkg::box_t o_box,
  output logic        o_reply,
  output logic [1:0]  o_status,
  output logic [4:0]  o_count,
  output logic        o_last
);
  import dra_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MRD   = 4'd1;
  localparam logic [3:0] S_MMUL  = 4'd2;
  localparam logic [3:0] S_MTEST = 4'd3;
  localparam logic [3:0] S_MMOVE = 4'd4;
  localparam logic [3:0] S_CRD   = 4'd5;
  localparam logic [3:0] S_CACC  = 4'd6;
  localparam logic [3:0] S_CWR   = 4'd7;
  localparam logic [3:0] S_POST  = 4'd8;
  localparam logic [3:0] S_GRD   = 4'd9;
  localparam logic [3:0] S_GOUT  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_APP   = 4'd12;

  logic [3:0]      state;
  logic [CntW-1:0] total;
  logic            pending;
  logic [IdxW-1:0] ia, ib;
  logic [CntW-1:0] ci;
  logic            is_grab;
  logic [4:0]      limit;

  assign s_ready = (state == S_IDLE) && !o_valid;
  assign wr_idx  = (state == S_APP) ? total[IdxW-1:0] : IdxW'(total - 1'b1);

  always_comb begin
    cmd = '0;
    cmd.a = ia;
    cmd.b = ib;
    case (state)
      S_IDLE:  cmd.op = (s_valid && s_ready) ? OP_LOAD : OP_NONE;
      S_MRD:   cmd.op = OP_MRD;
      S_MTEST: cmd.op = OP_MTEST;
      S_MMOVE: cmd.op = OP_MMOVE;
      S_CRD: begin
        cmd.op = OP_CRD;
        cmd.a = ci[IdxW-1:0];
      end
      S_CACC:  cmd.op = OP_CACC;
      S_CWR:   cmd.wr_acc0 = 1'b1;
      S_APP:   cmd.op = OP_APPEND;
      S_GRD: begin
        cmd.op = OP_CRD;
        cmd.a = ci[IdxW-1:0];
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
      pending <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      // S_GOUT reloads the output itself
      if (o_valid && o_ready && state != S_GOUT) o_valid <= 1'b0;
      case (state)
        S_IDLE: if (s_valid && s_ready) begin
          o_box <= '0; o_reply <= 1'b0; o_status <= ST_OK; o_count <= '0; o_last <= 1'b1;
          is_grab <= (mode == MODE_GRAB);
          limit <= lim;
          ia <= '0; ib <= IdxW'(1);
          case (mode)
            MODE_MARK: if (scan) begin
              state <= (total >= CntW'(MaxRects)) ? S_MRD : S_APP;
            end
            MODE_REQ: begin
              o_kind <= KIND_REPLY;
              o_valid <= 1'b1;
              if (!pending) begin
                if (total != '0) o_reply <= 1'b1;
                else pending <= 1'b1;
              end
            end
            MODE_GRAB: begin
              o_kind <= KIND_STATUS;
              if (!scan) begin
                o_status <= ST_NO_SCAN; o_valid <= 1'b1;
              end else if (lim == '0) begin
                o_status <= ST_ZERO_MAX; o_valid <= 1'b1;
              end else if (total > CntW'(1)) state <= S_MRD;
              else state <= S_POST;
            end
            default: ;
          endcase
        end
        S_MRD:   state <= S_MMUL;
        S_MMUL:  state <= S_MTEST;
        S_MTEST: begin
          if (sts.merge_ok) state <= S_MMOVE;
          else if (CntW'(ib) + 1'b1 < total) begin
            ib <= ib + 1'b1; state <= S_MRD;
          end else if (CntW'(ia) + 2'd2 < total) begin
            ia <= ia + 1'b1; ib <= ia + 2'd2; state <= S_MRD;
          end else state <= S_POST;
        end
        S_MMOVE: begin
          total <= total - 1'b1;
          ib <= ia + 1'b1;
          if (CntW'(ia) + 2'd2 < total) state <= S_MRD;
          else state <= S_POST;
        end
        S_POST: begin
          ci <= '0;
          if (is_grab ? (total > CntW'(limit)) : (total >= CntW'(MaxRects)))
            state <= S_CRD;
          else if (is_grab) begin
            if (total == '0) begin
              o_valid <= 1'b1; state <= S_IDLE;
            end else state <= S_GRD;
          end else state <= S_APP;
        end
        S_CRD:  state <= S_CACC;
        S_CACC: begin
          if (ci + 1'b1 < total) begin
            ci <= ci + 1'b1; state <= S_CRD;
          end else state <= S_CWR;
        end
        S_CWR: begin
          total <= CntW'(1);
          if (is_grab) begin
            ci <= '0; state <= S_GRD;
          end else state <= S_APP;
        end
        S_APP: begin
          total <= total + 1'b1;
          if (pending) begin
            pending <= 1'b0;
            o_kind <= KIND_UPDATE;
            o_valid <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_GRD: state <= S_GOUT;
        S_GOUT: if (!o_valid || o_ready) begin
          o_kind <= KIND_RECT;
          o_box <= rd_q;
          o_count <= 5'(total);
          o_last <= (ci + 1'b1 == total);
          o_valid <= 1'b1;
          if (ci + 1'b1 == total) begin
            total <= '0; state <= S_OUT;
          end else begin
            ci <= ci + 1'b1; state <= S_GRD;
          end
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // a waiting result beat holds until the sink takes it
  assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_ready |=> o_valid && $stable(o_kind) && $stable(o_box) &&
      $stable(o_reply) && $stable(o_status) && $stable(o_count) && $stable(o_last))
    else $error("result beat changed while waiting");
  assert property (@(posedge clk) disable iff (rst) total <= CntW'(MaxRects))
    else $error("rectangle count overflow");
  assert property (@(posedge clk) disable iff (rst)
    state == S_APP |-> total < CntW'(MaxRects))
    else $error("append into full store");
endmodule

>>> rtl/dirty_rect_accumulator.sv
// Dirty rectangle accumulator: keeps up to 16 damage rectangles, merges pairs
// whose bounding box is no larger than their summed area, collapses to one box
// when needed, and streams the list on a grab. A request answers in the cycle
// after its beat is accepted; a mark with room goes to the append state. A
// mark into a full list and a grab of two or more rectangles run the merge
// pass: each pair runs MRD, MMUL, MTEST in the single store read/area-test
// unit, a merging pair adds MMOVE, then POST decides; a collapse runs CRD and
// CACC per entry, then CWR; each grabbed rectangle runs GRD and GOUT, which
// waits while the sink stalls. No new beat is taken until the last result
// beat of the previous one is gone. Depends on dra_pkg, dra_ctrl, dra_datapath.
module dirty_rect_accumulator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // scanout_ready, rect_left, rect_top, rect_right,
                                // rect_bottom, max_rects, zero pad
  input  logic [1:0]  s_tuser,  // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // out_left, out_top, out_right, out_bottom,
                                // reply, status, rect_count
  output logic [1:0]  m_tuser,  // kind
  output logic        m_tlast
);
  import dra_pkg::*;

  dp_cmd_t         cmd;
  dp_sts_t         sts;
  box_t            in_rect, rd_q, o_box;
  logic [IdxW-1:0] wr_idx;
  logic            o_reply;
  logic [1:0]      o_status;
  logic [4:0]      o_count;

  assign in_rect.x1 = s_tdata[16:1];
  assign in_rect.y1 = s_tdata[32:17];
  assign in_rect.x2 = s_tdata[48:33];
  assign in_rect.y2 = s_tdata[64:49];

  dra_ctrl u_ctrl (
    .clk, .rst, .s_valid(s_tvalid), .s_ready(s_tready), .mode(s_tuser),
    .scan(s_tdata[0]), .lim(s_tdata[69:65]), .cmd, .wr_idx, .sts, .rd_q,
    .o_valid(m_tvalid), .o_ready(m_tready), .o_kind(m_tuser), .o_box,
    .o_reply, .o_status, .o_count, .o_last(m_tlast)
  );

  dra_datapath u_dp (
    .clk, .in_rect, .cmd, .wr_idx, .sts, .rd_q
  );

  assign m_tdata = {o_count, o_status, o_reply,
                    o_box.y2, o_box.x2, o_box.y1, o_box.x1};
endmodule

>>> tb/dirty_rect_accumulator_tb.sv
// Testbench for dirty_rect_accumulator: directed and random mark/request/grab
// beats checked against an in-bench model of the damage list.
// Depends on dra_pkg and the RTL top level.
module dirty_rect_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dra_pkg::*;

  typedef struct packed {
    logic [1:0]  mode;
    logic        scan;
    logic [15:0] x1, y1, x2, y2;
    logic [4:0]  lim;
  } mark_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] x1, y1, x2, y2;
    logic        reply;
    logic [1:0]  status;
    logic [4:0]  cnt;
    logic        last;
  } dmg_result_t;

  logic        clk, rst;
  logic        s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
  logic [71:0] s_tdata, m_tdata;
  logic [1:0]  s_tuser, m_tuser;

  dirty_rect_accumulator u_top (.*);

  mark_item_t  item_q[$];
  dmg_result_t expected_q[$];
  box_t        damage_list[MaxRects];
  int          damage_cnt;
  bit          update_armed;
  int          mismatches, results_seen, items_sent;
  bit          no_idle;
  bit          s_acc;
  int          src_gap, sink_gap;

  function automatic longint box_area(box_t r);
    return (longint'(r.x2) - longint'(r.x1)) * (longint'(r.y2) - longint'(r.y1));
  endfunction

  function automatic box_t bound(box_t p, box_t q);
    box_t r;
    r.x1 = p.x1 < q.x1 ? p.x1 : q.x1;
    r.y1 = p.y1 < q.y1 ? p.y1 : q.y1;
    r.x2 = p.x2 > q.x2 ? p.x2 : q.x2;
    r.y2 = p.y2 > q.y2 ? p.y2 : q.y2;
    return r;
  endfunction

  task automatic merge_list();
    int a, b;
    box_t bb;
    for (a = 0; a + 1 < damage_cnt; a++) begin
      b = a + 1;
      while (b < damage_cnt) begin
        bb = bound(damage_list[a], damage_list[b]);
        if (box_area(bb) <= box_area(damage_list[a]) + box_area(damage_list[b])) begin
          damage_list[a] = bb;
          damage_list[b] = damage_list[damage_cnt-1];
          damage_cnt--;
          b = a + 1;
        end else b++;
      end
    end
  endtask

  task automatic collapse_list();
    for (int i = 1; i < damage_cnt; i++) damage_list[0] = bound(damage_list[0], damage_list[i]);
    if (damage_cnt > 1) damage_cnt = 1;
  endtask

  function automatic dmg_result_t mk(logic [1:0] k, int rp, logic [1:0] st);
    dmg_result_t r;
    r = '0;
    r.kind = k; r.reply = rp[0]; r.status = st; r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_damage(mark_item_t it);
    box_t nb;
    dmg_result_t r;
    case (it.mode)
      MODE_MARK: begin
        if (it.scan) begin
          nb.x1 = it.x1; nb.y1 = it.y1; nb.x2 = it.x2; nb.y2 = it.y2;
          if (damage_cnt >= MaxRects) merge_list();
          if (damage_cnt >= MaxRects) collapse_list();
          damage_list[damage_cnt] = nb;
          damage_cnt++;
          if (update_armed) begin
            update_armed = 0;
            expected_q.push_back(mk(KIND_UPDATE, 0, ST_OK));
          end
        end
      end
      MODE_REQ: begin
        if (!update_armed && damage_cnt > 0) expected_q.push_back(mk(KIND_REPLY, 1, ST_OK));
        else begin
          if (!update_armed) update_armed = 1;
          expected_q.push_back(mk(KIND_REPLY, 0, ST_OK));
        end
      end
      MODE_GRAB: begin
        if (!it.scan) expected_q.push_back(mk(KIND_STATUS, 0, ST_NO_SCAN));
        else if (it.lim == 0) expected_q.push_back(mk(KIND_STATUS, 0, ST_ZERO_MAX));
        else begin
          merge_list();
          if (damage_cnt > it.lim) collapse_list();
          if (damage_cnt == 0) expected_q.push_back(mk(KIND_STATUS, 0, ST_OK));
          for (int i = 0; i < damage_cnt; i++) begin
            r = '0;
            r.kind = KIND_RECT;
            r.x1 = damage_list[i].x1; r.y1 = damage_list[i].y1;
            r.x2 = damage_list[i].x2; r.y2 = damage_list[i].y2;
            r.cnt = 5'(damage_cnt);
            r.last = (i + 1 == damage_cnt);
            expected_q.push_back(r);
          end
          damage_cnt = 0;
        end
      end
      default: ;
    endcase
  endtask

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // driver; s_acc says whether the beat on the bus went through at the last edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 0; src_gap <= 0;
    end else if (!(s_tvalid && !s_acc)) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1; s_tvalid <= 0;
      end else if (item_q.size() > 0 && (no_idle || $urandom_range(0, 7) != 0)) begin
        s_tvalid <= 1;
        s_tuser  <= item_q[0].mode;
        s_tdata  <= {2'b0, item_q[0].lim, item_q[0].y2, item_q[0].x2, item_q[0].y1,
                     item_q[0].x1, item_q[0].scan};
        predict_damage(item_q.pop_front());
        items_sent++;
      end else begin
        s_tvalid <= 0;
        if (!no_idle && item_q.size() > 0) src_gap <= $urandom_range(1, 7);
      end
    end
    if (!rst && !no_idle && sink_gap == 0 && $urandom_range(0, 9) == 0) begin
      sink_gap <= $urandom_range(1, 7); m_tready <= 0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1; m_tready <= (sink_gap == 1);
    end else m_tready <= 1;
  end

  // monitor
  always @(posedge clk) begin
    dmg_result_t got, want;
    s_acc <= !rst && s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
             m_tdata[64], m_tdata[66:65], m_tdata[71:67], m_tlast};
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp kind=%0d box=%0d,%0d,%0d,%0d rep=%0d st=%0d n=%0d l=%0d",
                     want.kind, want.x1, want.y1, want.x2, want.y2, want.reply,
                     want.status, want.cnt, want.last,
                     "\n          got kind=%0d box=%0d,%0d,%0d,%0d rep=%0d st=%0d n=%0d l=%0d",
                     got.kind, got.x1, got.y1, got.x2, got.y2, got.reply,
                     got.status, got.cnt, got.last);
        end
      end
    end
  end

  function automatic mark_item_t rand_item(logic [1:0] md);
    mark_item_t it;
    logic [15:0] a, b;
    it.mode = md;
    it.scan = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 3) == 0) begin
      it.x1 = 16'($urandom); it.y1 = 16'($urandom);
      it.x2 = 16'($urandom); it.y2 = 16'($urandom);
    end else begin
      a = 16'($urandom_range(0, 200)); b = 16'($urandom_range(0, 200));
      it.x1 = a; it.y1 = b;
      it.x2 = 16'(a + $urandom_range(0, 60)); it.y2 = 16'(b + $urandom_range(0, 60));
    end
    it.lim = $urandom_range(0, 9) == 0 ? 5'($urandom_range(17, 31))
                                       : 5'($urandom_range(0, 16));
    return it;
  endfunction

  function automatic mark_item_t dir(logic [1:0] md, int sc, int x1, int y1, int x2,
                                     int y2, int lim);
    mark_item_t it;
    it.mode = md; it.scan = sc[0];
    it.x1 = 16'(x1); it.y1 = 16'(y1); it.x2 = 16'(x2); it.y2 = 16'(y2);
    it.lim = 5'(lim);
    return it;
  endfunction

  initial begin
    int r, wait_cnt;
    rst = 1; s_tvalid = 0; s_tdata = '0; s_tuser = '0; m_tready = 0;
    damage_cnt = 0; update_armed = 0; mismatches = 0; results_seen = 0;
    items_sent = 0; no_idle = 0; sink_gap = 0; src_gap = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    // directed: empty request arms, pending request, mark answers it
    item_q.push_back(dir(MODE_REQ, 0, 0, 0, 0, 0, 0));
    item_q.push_back(dir(MODE_REQ, 1, 0, 0, 0, 0, 0));
    item_q.push_back(dir(MODE_MARK, 0, 1, 1, 2, 2, 0));
    item_q.push_back(dir(MODE_MARK, 1, 0, 0, 65535, 65535, 31));
    item_q.push_back(dir(MODE_REQ, 1, 0, 0, 0, 0, 0));
    item_q.push_back(dir(MODE_GRAB, 0, 0, 0, 0, 0, 4));
    item_q.push_back(dir(MODE_GRAB, 1, 0, 0, 0, 0, 0));
    item_q.push_back(dir(2'd3, 1, 5, 5, 9, 9, 3));
    item_q.push_back(dir(MODE_GRAB, 1, 65535, 65535, 65535, 65535, 16));
    item_q.push_back(dir(MODE_GRAB, 1, 0, 0, 0, 0, 1));
    // reversed edges, then overflow the list and grab with small limit
    item_q.push_back(dir(MODE_MARK, 1, 100, 100, 10, 10, 0));
    for (int i = 0; i < 17; i++)
      item_q.push_back(dir(MODE_MARK, 1, i * 300, i * 7, i * 300 + 5, i * 7 + 3, 0));
    item_q.push_back(dir(MODE_GRAB, 1, 0, 0, 0, 0, 2));
    for (int i = 0; i < 300; i++) begin
      r = $urandom_range(0, 99);
      if (r < 65) item_q.push_back(rand_item(MODE_MARK));
      else if (r < 77) item_q.push_back(rand_item(MODE_REQ));
      else if (r < 98) item_q.push_back(rand_item(MODE_GRAB));
      else item_q.push_back(rand_item(2'd3));
      if (i == 240) item_q.push_back(dir(MODE_GRAB, 1, 0, 0, 0, 0, 16));
    end
    while (item_q.size() > 40) @(posedge clk);
    no_idle = 1;
    while (item_q.size() > 0 || (s_tvalid && !s_tready)) @(posedge clk);
    wait_cnt = 0;
    while (expected_q.size() > 0 && wait_cnt < 20000) begin
      @(posedge clk); wait_cnt++;
    end
    repeat (400) @(posedge clk);
    $display("covered %0d input beats and %0d result beats: marks, requests, grabs,",
             items_sent, results_seen);
    $display("list overflow merge/collapse, error statuses and the unused mode");
    if (mismatches == 0 && expected_q.size() == 0) $display("dirty_rect_accumulator_tb: clean");
    else begin
      $display("%0d mismatches, %0d beats never seen", mismatches, expected_q.size());
      $display("dirty_rect_accumulator_tb: errors");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("timeout");
    $display("dirty_rect_accumulator_tb: errors");
    $finish;
  end
endmodule

>>> sim.f
rtl/dra_pkg.sv
rtl/dra_datapath.sv
rtl/dra_ctrl.sv
rtl/dirty_rect_accumulator.sv
tb/dirty_rect_accumulator_tb.sv
